FILE: hdl/dlmh_pkg.sv
// ----------------------------------------------------------------------------
// Debug link mailbox package
// Shared types and fixed constants of the console-side debug mailbox.
// ----------------------------------------------------------------------------
`default_nettype none

package dlmh_pkg;

  // Input item commands.
  typedef enum logic [1:0] {
    CMD_BUS_READ  = 2'd0,
    CMD_BUS_WRITE = 2'd1,
    CMD_HOST_PUSH = 2'd2,
    CMD_HOST_READ = 2'd3
  } cmd_e;

  // Source of the read data word in the output stage.
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_FIFO,
    RD_RESP,
    RD_STATUS
  } rd_sel_e;

  localparam int unsigned LEN_W = 9;   // lengths and sizes, up to 256
  localparam int unsigned OFS_W = 10;  // byte offsets of open transfers

  localparam logic [4:0]  ADDR_DATA   = 5'd0;
  localparam logic [4:0]  ADDR_STATUS = 5'd4;

  localparam logic [31:0] HS_START    = 32'h0000_0082;
  localparam logic [7:0]  OP_FILE     = 8'h42;
  localparam logic [7:0]  OP_PROBE    = 8'h49;
  localparam logic [7:0]  OP_UPLOAD   = 8'h44;

  localparam logic [LEN_W-1:0] MODE_READ  = 9'd2;
  localparam logic [LEN_W-1:0] MODE_WRITE = 9'd3;
  localparam logic [LEN_W-1:0] ZERO_RESP_SIZE = 9'd4;

  localparam logic [31:0] STATUS_BASE = 32'h0000_0004;
  localparam logic [31:0] STATUS_BUSY = 32'h0000_0002;

endpackage

`default_nettype wire

FILE: hdl/dlmh_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dlmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/debug_link_mailbox_handshake.sv
// ----------------------------------------------------------------------------
// Debug link mailbox with handshake
// Console-side mailbox: data and status registers, a word queue for the
// handshake words, host response slots and a command buffer.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+-------------------------------
//   in      | to block  | in_valid_i/in_stall_o | command, bus_address,
//           |           |                       | write_data, host_byte,
//           |           |                       | host_last, buffer_index
//   out     | from block| out_valid_o/out_stall_i| read_data, push_accepted,
//           |           |                       | command_ready, buffer_byte
//
// Every item gives exactly one result, presented in the cycle after its
// transfer. All state updates and memory accesses happen at the transfer
// edge; the output stage then combines the registered RAM read data with
// registered selects. A new item can be taken every cycle. The input stalls
// only while a result sits in the output stage and the output side stalls.
// Reset is asynchronous and clears all control state; no clearing pass is
// needed (the command buffer uses one valid bit per four-byte row).
// ----------------------------------------------------------------------------
`default_nettype none

module debug_link_mailbox_handshake #(
  parameter int unsigned WORD_QUEUE_DEPTH = 64,
  parameter int unsigned RESPONSE_SLOTS   = 4,
  parameter int unsigned CHUNK_BYTES      = 256,
  parameter int unsigned CMD_BUFFER_BYTES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [4:0]  bus_address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [7:0]  host_byte_i,
  input  wire logic        host_last_i,
  input  wire logic [7:0]  buffer_index_i,

  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      read_data_o,
  output logic             push_accepted_o,
  output logic             command_ready_o,
  output logic [7:0]       buffer_byte_o
);

  localparam int unsigned LEN_W = dlmh_pkg::LEN_W;
  localparam int unsigned OFS_W = dlmh_pkg::OFS_W;

  // The word queue is a ring of an even number of entries split over two
  // banks by entry parity, so that a handshake can queue two words at once.
  localparam int unsigned HALF  = (WORD_QUEUE_DEPTH + 1) / 2;
  localparam int unsigned PHYS  = 2 * HALF;
  localparam int unsigned PW    = $clog2(PHYS);
  localparam int unsigned FCW   = $clog2(WORD_QUEUE_DEPTH + 1);

  // Response store: four byte lanes, addressed by {slot, row}.
  localparam int unsigned ROWS  = (CHUNK_BYTES + 3) / 4;
  localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned SW    = (RESPONSE_SLOTS > 1) ? $clog2(RESPONSE_SLOTS) : 1;
  localparam int unsigned RCW   = $clog2(RESPONSE_SLOTS + 1);
  localparam int unsigned RDEP  = 2 ** (SW + RW);

  // Command buffer: four byte lanes, one row per four bytes.
  localparam int unsigned CROWS = (CMD_BUFFER_BYTES + 3) / 4;
  localparam int unsigned CRW   = (CROWS > 1) ? $clog2(CROWS) : 1;

  localparam logic [LEN_W-1:0] CMD_LEN = LEN_W'(CMD_BUFFER_BYTES);

  // ---------------------------------------------------------------- state
  logic [PW-1:0]    frd_q, frd_d, fwr_q, fwr_d;
  logic [FCW-1:0]   fcnt_q, fcnt_d;
  logic [SW-1:0]    rrd_q, rrd_d, rwr_q, rwr_d;
  logic [RCW-1:0]   rcnt_q, rcnt_d;
  logic [LEN_W-1:0] rfill_q, rfill_d;
  logic [LEN_W-1:0] rsize_q [RESPONSE_SLOTS];
  logic             hs_pend_q, hs_pend_d, hs_wr_q, hs_wr_d;
  logic [LEN_W-1:0] hs_len_q, hs_len_d;
  logic             wr_act_q, wr_act_d;
  logic [OFS_W-1:0] wr_ofs_q, wr_ofs_d;
  logic             rd_act_q, rd_act_d;
  logic [OFS_W-1:0] rd_ofs_q, rd_ofs_d;
  logic             rdy_q, rdy_d;
  logic [7:0]       opcode_q, opcode_d;
  logic [CROWS-1:0] cvalid_q, cvalid_d;

  // Output stage.
  logic                s1_valid_q;
  dlmh_pkg::rd_sel_e   s1_sel_q, s1_sel_d;
  logic                s1_bank_q, s1_bank_d;
  logic [3:0]          s1_mask_q, s1_mask_d;
  logic                s1_busy_q, s1_busy_d;
  logic                s1_acc_q, s1_acc_d;
  logic                s1_host_q, s1_host_d;
  logic [1:0]          s1_lane_q, s1_lane_d;

  // Memory ports.
  logic             fq_we [2];
  logic [PW-2:0]    fq_waddr [2];
  logic [LEN_W-1:0] fq_wdata [2];
  logic [LEN_W-1:0] fq_rdata [2];
  logic             fq_re;
  logic [PW-2:0]    fq_raddr;

  logic [3:0]        rs_we;
  logic [SW+RW-1:0]  rs_waddr;
  logic [7:0]        rs_wdata;
  logic              rs_re;
  logic [SW+RW-1:0]  rs_raddr;
  logic [7:0]        rs_rdata [4];

  logic              cb_we;
  logic [CRW-1:0]    cb_waddr;
  logic              cb_re;
  logic [CRW-1:0]    cb_raddr;
  logic [7:0]        cb_rdata [4];

  logic             rsize_we;
  logic [SW-1:0]    rsize_idx;
  logic [LEN_W-1:0] rsize_val;

  logic accept;

  function automatic logic [PW-1:0] fq_inc(input logic [PW-1:0] p);
    fq_inc = (p == PW'(PHYS - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] p);
    slot_inc = (p == SW'(RESPONSE_SLOTS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = s1_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // ------------------------------------------------------- item processing
  always_comb begin
    logic [PW-1:0]    p1;
    logic             w0, w1;
    logic [LEN_W-1:0] size;
    logic [LEN_W-1:0] new_fill;
    logic [OFS_W-1:0] ofs4;
    logic             finish;

    frd_d = frd_q;  fwr_d = fwr_q;  fcnt_d = fcnt_q;
    rrd_d = rrd_q;  rwr_d = rwr_q;  rcnt_d = rcnt_q;  rfill_d = rfill_q;
    hs_pend_d = hs_pend_q;  hs_wr_d = hs_wr_q;  hs_len_d = hs_len_q;
    wr_act_d = wr_act_q;  wr_ofs_d = wr_ofs_q;
    rd_act_d = rd_act_q;  rd_ofs_d = rd_ofs_q;
    rdy_d = rdy_q;  opcode_d = opcode_q;  cvalid_d = cvalid_q;

    s1_sel_d  = dlmh_pkg::RD_ZERO;
    s1_bank_d = s1_bank_q;
    s1_mask_d = '0;
    s1_busy_d = 1'b0;
    s1_acc_d  = 1'b0;
    s1_host_d = 1'b0;
    s1_lane_d = buffer_index_i[1:0];

    for (int b = 0; b < 2; b++) begin
      fq_we[b]    = 1'b0;
      fq_waddr[b] = '0;
      fq_wdata[b] = '0;
    end
    fq_re    = 1'b0;
    fq_raddr = frd_q[PW-1:1];

    rs_we    = '0;
    rs_waddr = {rwr_q, rfill_q[RW+1:2]};
    rs_wdata = host_byte_i;
    rs_re    = 1'b0;
    rs_raddr = {rrd_q, rd_ofs_q[RW+1:2]};

    cb_we    = 1'b0;
    cb_waddr = wr_ofs_q[CRW+1:2];
    cb_re    = 1'b0;
    cb_raddr = buffer_index_i[CRW+1:2];

    rsize_we  = 1'b0;
    rsize_idx = rwr_q;
    rsize_val = rfill_q;

    p1       = fq_inc(fwr_q);
    w0       = fcnt_q < FCW'(WORD_QUEUE_DEPTH);
    w1       = ({1'b0, fcnt_q} + 1'b1) < (FCW + 1)'(WORD_QUEUE_DEPTH);
    size     = (rcnt_q != '0) ? rsize_q[rrd_q] : '0;
    new_fill = rfill_q;
    ofs4     = '0;
    finish   = 1'b0;

    if (accept) begin
      unique case (dlmh_pkg::cmd_e'(command_i))
        dlmh_pkg::CMD_BUS_READ: begin
          if (bus_address_i == dlmh_pkg::ADDR_DATA) begin
            if (fcnt_q != '0) begin
              fq_re     = 1'b1;
              s1_sel_d  = dlmh_pkg::RD_FIFO;
              s1_bank_d = frd_q[0];
              frd_d     = fq_inc(frd_q);
              fcnt_d    = fcnt_q - 1'b1;
            end else if (rd_act_q) begin
              if (size == '0) begin
                rd_act_d = 1'b0;
                rd_ofs_d = '0;
              end else begin
                rs_re    = 1'b1;
                s1_sel_d = dlmh_pkg::RD_RESP;
                for (int k = 0; k < 4; k++) begin
                  s1_mask_d[k] = (rd_ofs_q + OFS_W'(k)) < OFS_W'(size);
                end
                ofs4 = rd_ofs_q + OFS_W'(4);
                rd_ofs_d = ofs4;
                if (ofs4 >= OFS_W'(size)) begin
                  rd_act_d = 1'b0;
                  rd_ofs_d = '0;
                  rrd_d    = slot_inc(rrd_q);
                  rcnt_d   = rcnt_q - 1'b1;
                end
              end
            end
          end else if (bus_address_i == dlmh_pkg::ADDR_STATUS) begin
            s1_sel_d  = dlmh_pkg::RD_STATUS;
            s1_busy_d = (fcnt_q != '0) || rd_act_q || (rcnt_q != '0);
          end
        end

        dlmh_pkg::CMD_BUS_WRITE: begin
          if (bus_address_i == dlmh_pkg::ADDR_DATA) begin
            if (write_data_i == dlmh_pkg::HS_START && !hs_pend_q && !wr_act_q) begin
              // Start of a handshake: queue the mode word and the length word.
              hs_pend_d = 1'b1;
              hs_wr_d   = (rcnt_q == '0);
              hs_len_d  = (rcnt_q == '0) ? CMD_LEN : size;
              if (w0) begin
                fq_we[fwr_q[0]]    = 1'b1;
                fq_waddr[fwr_q[0]] = fwr_q[PW-1:1];
                fq_wdata[fwr_q[0]] = (rcnt_q == '0) ? dlmh_pkg::MODE_WRITE
                                                    : dlmh_pkg::MODE_READ;
              end
              if (w1) begin
                fq_we[p1[0]]    = 1'b1;
                fq_waddr[p1[0]] = p1[PW-1:1];
                fq_wdata[p1[0]] = hs_len_d;
              end
              fwr_d  = w1 ? fq_inc(p1) : (w0 ? p1 : fwr_q);
              fcnt_d = fcnt_q + FCW'(w0) + FCW'(w1);
            end else if (hs_pend_q) begin
              if (write_data_i == {{(32 - LEN_W){1'b0}}, hs_len_q}) begin
                if (!hs_wr_q) begin
                  rd_act_d = 1'b1;
                  rd_ofs_d = '0;
                end else begin
                  wr_act_d = 1'b1;
                  wr_ofs_d = '0;
                end
              end
              hs_pend_d = 1'b0;
            end else if (wr_act_q) begin
              // One word of the command: four bytes, most significant first.
              if (wr_ofs_q < OFS_W'(CMD_BUFFER_BYTES)) begin
                cb_we = 1'b1;
                cvalid_d[cb_waddr] = 1'b1;
                if (wr_ofs_q == '0) begin
                  opcode_d = write_data_i[31:24];
                end
              end
              wr_ofs_d = wr_ofs_q + OFS_W'(4);
              finish   = wr_ofs_d >= OFS_W'(CMD_LEN);
            end
          end
        end

        dlmh_pkg::CMD_HOST_PUSH: begin
          if (rcnt_q < RCW'(RESPONSE_SLOTS)) begin
            s1_acc_d = 1'b1;
            if (rfill_q < LEN_W'(CHUNK_BYTES)) begin
              rs_we[rfill_q[1:0]] = 1'b1;
              new_fill = rfill_q + 1'b1;
            end
            rfill_d = new_fill;
            if (host_last_i) begin
              rsize_we  = 1'b1;
              rsize_val = new_fill;
              rwr_d     = slot_inc(rwr_q);
              rcnt_d    = rcnt_q + 1'b1;
              rfill_d   = '0;
              rdy_d     = 1'b0;
            end
          end
        end

        dlmh_pkg::CMD_HOST_READ: begin
          cb_re = 1'b1;
          if (buffer_index_i < 8'(CMD_BUFFER_BYTES)
              || CMD_BUFFER_BYTES > 255) begin
            s1_host_d = cvalid_q[cb_raddr];
          end
        end

        default: ;
      endcase
    end

    // Completion of a command write.
    if (finish) begin
      wr_act_d = 1'b0;
      if (opcode_d == dlmh_pkg::OP_FILE || opcode_d == dlmh_pkg::OP_PROBE) begin
        rdy_d = 1'b1;
      end else if (opcode_d != dlmh_pkg::OP_UPLOAD) begin
        if (rcnt_q < RCW'(RESPONSE_SLOTS)) begin
          // Four zero bytes into the current write slot.
          rs_we     = '1;
          rs_waddr  = {rwr_q, {RW{1'b0}}};
          rs_wdata  = '0;
          rsize_we  = 1'b1;
          rsize_val = dlmh_pkg::ZERO_RESP_SIZE;
          rwr_d     = slot_inc(rwr_q);
          rcnt_d    = rcnt_q + 1'b1;
          rfill_d   = '0;
        end
      end
    end
  end

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frd_q <= '0;  fwr_q <= '0;  fcnt_q <= '0;
      rrd_q <= '0;  rwr_q <= '0;  rcnt_q <= '0;  rfill_q <= '0;
      hs_pend_q <= 1'b0;  hs_wr_q <= 1'b0;  hs_len_q <= '0;
      wr_act_q <= 1'b0;  wr_ofs_q <= '0;
      rd_act_q <= 1'b0;  rd_ofs_q <= '0;
      rdy_q <= 1'b0;  opcode_q <= '0;  cvalid_q <= '0;
      s1_valid_q <= 1'b0;
      s1_sel_q   <= dlmh_pkg::RD_ZERO;
    end else begin
      frd_q <= frd_d;  fwr_q <= fwr_d;  fcnt_q <= fcnt_d;
      rrd_q <= rrd_d;  rwr_q <= rwr_d;  rcnt_q <= rcnt_d;  rfill_q <= rfill_d;
      hs_pend_q <= hs_pend_d;  hs_wr_q <= hs_wr_d;  hs_len_q <= hs_len_d;
      wr_act_q <= wr_act_d;  wr_ofs_q <= wr_ofs_d;
      rd_act_q <= rd_act_d;  rd_ofs_q <= rd_ofs_d;
      rdy_q <= rdy_d;  opcode_q <= opcode_d;  cvalid_q <= cvalid_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
        s1_sel_q   <= s1_sel_d;
      end else if (!out_stall_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bank_q <= s1_bank_d;
      s1_mask_q <= s1_mask_d;
      s1_busy_q <= s1_busy_d;
      s1_acc_q  <= s1_acc_d;
      s1_host_q <= s1_host_d;
      s1_lane_q <= s1_lane_d;
    end
    if (rsize_we) begin
      rsize_q[rsize_idx] <= rsize_val;
    end
  end

  // ------------------------------------------------------------- memories
  for (genvar b = 0; b < 2; b++) begin : g_fq
    dlmh_ram #(.WIDTH(LEN_W), .DEPTH(HALF)) u_fq (
      .clk_i   (clk_i),
      .we_i    (fq_we[b]),
      .waddr_i (fq_waddr[b]),
      .wdata_i (fq_wdata[b]),
      .re_i    (fq_re),
      .raddr_i (fq_raddr),
      .rdata_o (fq_rdata[b])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_lane
    dlmh_ram #(.WIDTH(8), .DEPTH(RDEP)) u_resp (
      .clk_i   (clk_i),
      .we_i    (rs_we[k]),
      .waddr_i (rs_waddr),
      .wdata_i (rs_wdata),
      .re_i    (rs_re),
      .raddr_i (rs_raddr),
      .rdata_o (rs_rdata[k])
    );

    dlmh_ram #(.WIDTH(8), .DEPTH(CROWS)) u_cmd (
      .clk_i   (clk_i),
      .we_i    (cb_we),
      .waddr_i (cb_waddr),
      .wdata_i (write_data_i[31 - 8 * k -: 8]),
      .re_i    (cb_re),
      .raddr_i (cb_raddr),
      .rdata_o (cb_rdata[k])
    );
  end

  // --------------------------------------------------------------- output
  always_comb begin
    unique case (s1_sel_q)
      dlmh_pkg::RD_FIFO:
        read_data_o = {{(32 - LEN_W){1'b0}}, fq_rdata[s1_bank_q]};
      dlmh_pkg::RD_RESP:
        read_data_o = {rs_rdata[0] & {8{s1_mask_q[0]}},
                       rs_rdata[1] & {8{s1_mask_q[1]}},
                       rs_rdata[2] & {8{s1_mask_q[2]}},
                       rs_rdata[3] & {8{s1_mask_q[3]}}};
      dlmh_pkg::RD_STATUS:
        read_data_o = dlmh_pkg::STATUS_BASE
                    | (s1_busy_q ? dlmh_pkg::STATUS_BUSY : 32'd0);
      default:
        read_data_o = '0;
    endcase
  end

  assign out_valid_o     = s1_valid_q;
  assign push_accepted_o = s1_acc_q;
  assign command_ready_o = rdy_q;
  assign buffer_byte_o   = s1_host_q ? cb_rdata[s1_lane_q] : 8'd0;

endmodule

`default_nettype wire

FILE: sim/tb_debug_link_mailbox_handshake.sv
// ----------------------------------------------------------------------------
// Debug link mailbox testbench
// Drives bus accesses and host operations into the mailbox, predicts every
// result with a cycle-free model of the mailbox kept in this file, and checks
// each result in order under random idle gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_debug_link_mailbox_handshake;

  // These mirror the default parameters of the block under test.
  localparam int unsigned WORD_DEPTH  = 64;
  localparam int unsigned SLOTS       = 4;
  localparam int unsigned CHUNK       = 256;
  localparam int unsigned CMD_BYTES   = 256;
  localparam int unsigned ITEM_TARGET = 550;

  typedef struct packed {
    logic [31:0] read_data;
    logic        push_accepted;
    logic        command_ready;
    logic [7:0]  buffer_byte;
  } mbox_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  command_i;
  logic [4:0]  bus_address_i;
  logic [31:0] write_data_i;
  logic [7:0]  host_byte_i;
  logic        host_last_i;
  logic [7:0]  buffer_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] read_data_o;
  logic        push_accepted_o;
  logic        command_ready_o;
  logic [7:0]  buffer_byte_o;

  debug_link_mailbox_handshake u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .bus_address_i  (bus_address_i),
    .write_data_i   (write_data_i),
    .host_byte_i    (host_byte_i),
    .host_last_i    (host_last_i),
    .buffer_index_i (buffer_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .push_accepted_o(push_accepted_o),
    .command_ready_o(command_ready_o),
    .buffer_byte_o  (buffer_byte_o)
  );

  // Shadow copy of the mailbox state, updated once per accepted transfer.
  logic [31:0] mb_words [WORD_DEPTH];
  int unsigned words_rd, words_wr, words_count;
  logic [7:0]  slot_bytes [SLOTS][CHUNK];
  int unsigned slot_size [SLOTS];
  int unsigned slot_rd, slot_wr, slot_count, slot_fill;
  bit          hs_open, hs_write;
  int unsigned hs_len;
  bit          cw_active;
  int unsigned cw_expected, cw_offset;
  logic [7:0]  cmd_mem [CMD_BYTES];
  bit          rr_active;
  int unsigned rr_offset;
  bit          ready_flag;

  mbox_result_t pending_results [$];
  int unsigned  error_count;
  int unsigned  items_sent;
  int unsigned  results_checked;
  int unsigned  handshakes_run;

  // Idle control shared by the sender and the receiver.
  bit          no_idle;
  int unsigned hold_request;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The run is bounded by a fixed time far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Mailbox prediction
  // ---------------------------------------------------------------------------

  function void queue_word(input logic [31:0] w);
    // A word offered while the queue is full is lost.
    if (words_count >= WORD_DEPTH) return;
    mb_words[words_wr] = w;
    words_wr = (words_wr + 1) % WORD_DEPTH;
    words_count++;
  endfunction

  function void close_slot(input int unsigned size);
    slot_size[slot_wr] = size;
    slot_wr = (slot_wr + 1) % SLOTS;
    slot_count++;
    slot_fill = 0;
  endfunction

  function void finish_command();
    logic [7:0] op;
    op = cmd_mem[0];
    if (op == dlmh_pkg::OP_FILE || op == dlmh_pkg::OP_PROBE) begin
      ready_flag = 1'b1;
    end else if (op != dlmh_pkg::OP_UPLOAD && slot_count < SLOTS) begin
      // Unknown opcodes answer with four zero bytes, taking the slot that the
      // host may be filling; its partial bytes are thrown away.
      for (int k = 0; k < 4; k++) slot_bytes[slot_wr][k] = 8'h00;
      close_slot(dlmh_pkg::ZERO_RESP_SIZE);
    end
  endfunction

  function void data_port_write(input logic [31:0] d);
    int unsigned p;
    if (d == dlmh_pkg::HS_START && !hs_open && !cw_active) begin
      hs_write = (slot_count == 0);
      hs_len   = hs_write ? CMD_BYTES : slot_size[slot_rd];
      hs_open  = 1'b1;
      queue_word(hs_write ? 32'(dlmh_pkg::MODE_WRITE) : 32'(dlmh_pkg::MODE_READ));
      queue_word(32'(hs_len));
      return;
    end
    if (hs_open) begin
      // A wrong length just closes the handshake.
      if (d == 32'(hs_len)) begin
        if (!hs_write) begin
          rr_active = 1'b1;
          rr_offset = 0;
        end else begin
          cw_active   = 1'b1;
          cw_expected = hs_len;
          cw_offset   = 0;
        end
      end
      hs_open = 1'b0;
      return;
    end
    if (cw_active) begin
      for (int k = 0; k < 4; k++) begin
        p = cw_offset + k;
        if (p < CMD_BYTES && p < cw_expected) cmd_mem[p] = d[31-8*k -: 8];
      end
      cw_offset += 4;
      if (cw_offset >= cw_expected) begin
        cw_active = 1'b0;
        finish_command();
      end
    end
  endfunction

  function logic [31:0] data_port_read();
    logic [31:0] w;
    int unsigned size, p;
    w = '0;
    if (words_count != 0) begin
      w = mb_words[words_rd];
      words_rd = (words_rd + 1) % WORD_DEPTH;
      words_count--;
      return w;
    end
    if (!rr_active) return w;
    size = (slot_count != 0) ? slot_size[slot_rd] : 0;
    if (size == 0) begin
      rr_active = 1'b0;
      rr_offset = 0;
      return w;
    end
    for (int k = 0; k < 4; k++) begin
      p = rr_offset + k;
      if (p < size && p < CHUNK) w[31-8*k -: 8] = slot_bytes[slot_rd][p];
    end
    rr_offset += 4;
    if (rr_offset >= size) begin
      rr_active = 1'b0;
      rr_offset = 0;
      slot_rd = (slot_rd + 1) % SLOTS;
      slot_count--;
    end
    return w;
  endfunction

  function mbox_result_t mailbox_predict(input dlmh_pkg::cmd_e cmd,
                                         input logic [4:0] addr,
                                         input logic [31:0] wdata,
                                         input logic [7:0] hbyte, input logic hlast,
                                         input logic [7:0] bidx);
    mbox_result_t r;
    r = '0;
    case (cmd)
      dlmh_pkg::CMD_BUS_READ: begin
        if (addr == dlmh_pkg::ADDR_DATA) begin
          r.read_data = data_port_read();
        end else if (addr == dlmh_pkg::ADDR_STATUS) begin
          r.read_data = dlmh_pkg::STATUS_BASE;
          if (words_count != 0 || rr_active || slot_count != 0)
            r.read_data |= dlmh_pkg::STATUS_BUSY;
        end
      end
      dlmh_pkg::CMD_BUS_WRITE: begin
        if (addr == dlmh_pkg::ADDR_DATA) data_port_write(wdata);
      end
      dlmh_pkg::CMD_HOST_PUSH: begin
        if (slot_count < SLOTS) begin
          r.push_accepted = 1'b1;
          // Bytes past the chunk size are taken but not stored.
          if (slot_fill < CHUNK) begin
            slot_bytes[slot_wr][slot_fill] = hbyte;
            slot_fill++;
          end
          if (hlast) begin
            close_slot(slot_fill);
            ready_flag = 1'b0;
          end
        end
      end
      default: begin
        if (int'(bidx) < CMD_BYTES) r.buffer_byte = cmd_mem[bidx];
      end
    endcase
    r.command_ready = ready_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  function int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one item and waits for its transfer; the expected result is
  // recorded at the edge where the block takes it.
  task automatic send_item(input dlmh_pkg::cmd_e cmd, input logic [4:0] addr,
                           input logic [31:0] wdata, input logic [7:0] hbyte,
                           input logic hlast, input logic [7:0] bidx);
    int unsigned gap;
    bit          stalled;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    bus_address_i  <= addr;
    write_data_i   <= wdata;
    host_byte_i    <= hbyte;
    host_last_i    <= hlast;
    buffer_index_i <= bidx;
    // Stall is sampled mid-cycle, where it is settled for the coming edge.
    forever begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (!stalled) break;
    end
    pending_results.push_back(mailbox_predict(cmd, addr, wdata, hbyte, hlast, bidx));
    items_sent++;
  endtask

  task automatic bus_write(input logic [31:0] d);
    send_item(dlmh_pkg::CMD_BUS_WRITE, dlmh_pkg::ADDR_DATA, d, 8'($urandom),
              1'($urandom), 8'($urandom));
  endtask

  task automatic bus_read(input logic [4:0] addr);
    send_item(dlmh_pkg::CMD_BUS_READ, addr, $urandom, 8'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  task automatic host_push(input logic [7:0] b, input logic last);
    send_item(dlmh_pkg::CMD_HOST_PUSH, 5'($urandom), $urandom, b, last, 8'($urandom));
  endtask

  task automatic host_read(input logic [7:0] idx);
    send_item(dlmh_pkg::CMD_HOST_READ, 5'($urandom), $urandom, 8'($urandom),
              1'($urandom), idx);
  endtask

  // Pushes a chunk of len random bytes; the last one is flagged if close is set.
  task automatic push_chunk(input int unsigned len, input bit close);
    for (int unsigned i = 0; i < len; i++)
      host_push(8'($urandom), close && (i == len - 1));
  endtask

  // One console handshake: start word, both queued words, the echoed length
  // (spoiled on request), then the read or command write that it opens.
  task automatic console_handshake(input bit spoil, input logic [7:0] opcode);
    int unsigned len, nwords;
    bit          is_write;
    handshakes_run++;
    bus_write(dlmh_pkg::HS_START);
    bus_read(dlmh_pkg::ADDR_DATA);
    bus_read(dlmh_pkg::ADDR_DATA);
    if (!hs_open) return;
    len      = hs_len;
    is_write = hs_write;
    bus_write(spoil ? 32'(len) ^ (32'd1 << $urandom_range(0, 31)) : 32'(len));
    if (spoil) return;
    if (!is_write) begin
      nwords = (len + 3) / 4 + $urandom_range(0, 1);
      repeat (nwords) bus_read(dlmh_pkg::ADDR_DATA);
      bus_read(dlmh_pkg::ADDR_STATUS);
    end else begin
      bus_write({opcode, 24'($urandom)});
      for (int unsigned i = 4; i < len; i += 4) bus_write($urandom);
    end
  endtask

  task automatic drain_responses();
    while (slot_count != 0) console_handshake(1'b0, dlmh_pkg::OP_UPLOAD);
  endtask

  function logic [7:0] pick_opcode();
    case ($urandom_range(0, 3))
      0:       return dlmh_pkg::OP_FILE;
      1:       return dlmh_pkg::OP_PROBE;
      2:       return dlmh_pkg::OP_UPLOAD;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and result checker
  // ---------------------------------------------------------------------------

  // Random output stalls, with an occasional long one; a requested hold-off
  // keeps the output stalled for a counted number of cycles.
  initial begin
    int unsigned long_left;
    long_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        out_stall_i <= 1'b1;
        hold_request--;
      end else if (no_idle) begin
        out_stall_i <= 1'b0;
      end else if (long_left != 0) begin
        out_stall_i <= 1'b1;
        long_left--;
      end else if ($urandom_range(0, 199) == 0) begin
        long_left = $urandom_range(10, 40);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  // Compares every result transfer with the oldest expectation.
  initial begin
    mbox_result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting: read_data %h", read_data_o);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          if (read_data_o !== want.read_data) begin
            $error("read_data expected %h actual %h", want.read_data, read_data_o);
            error_count++;
          end
          if (push_accepted_o !== want.push_accepted) begin
            $error("push_accepted expected %b actual %b",
                   want.push_accepted, push_accepted_o);
            error_count++;
          end
          if (command_ready_o !== want.command_ready) begin
            $error("command_ready expected %b actual %b",
                   want.command_ready, command_ready_o);
            error_count++;
          end
          if (buffer_byte_o !== want.buffer_byte) begin
            $error("buffer_byte expected %h actual %h", want.buffer_byte, buffer_byte_o);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register map corners, a small response read back and a spoiled handshake.
  task automatic test_register_corners();
    bus_read(dlmh_pkg::ADDR_STATUS);
    bus_read(dlmh_pkg::ADDR_DATA);
    bus_read(5'd31);
    send_item(dlmh_pkg::CMD_BUS_WRITE, 5'd31, 32'hFFFF_FFFF, 8'hFF, 1'b1, 8'hFF);
    bus_write(32'h0000_0000);
    host_read(8'd0);
    host_read(8'd255);
    host_push(8'h00, 1'b0);
    host_push(8'hFF, 1'b0);
    host_push(8'hA5, 1'b1);
    bus_read(dlmh_pkg::ADDR_STATUS);
    console_handshake(1'b1, dlmh_pkg::OP_UPLOAD);
    console_handshake(1'b0, dlmh_pkg::OP_UPLOAD);
    bus_read(dlmh_pkg::ADDR_STATUS);
  endtask

  // Command writes with every opcode class, host reads of the buffer, and the
  // ready flag cleared by a committed host chunk.
  task automatic test_command_write();
    drain_responses();
    console_handshake(1'b0, dlmh_pkg::OP_FILE);
    host_read(8'd0);
    host_read(8'd255);
    push_chunk(3, 1'b1);
    drain_responses();
    console_handshake(1'b0, dlmh_pkg::OP_UPLOAD);
    console_handshake(1'b0, dlmh_pkg::OP_PROBE);
    drain_responses();
    // The zero response of an unknown opcode lands on a half-pushed chunk.
    push_chunk(5, 1'b0);
    console_handshake(1'b0, 8'h00);
    host_read(8'd1);
    drain_responses();
  endtask

  // Fills the handshake word queue past its depth, then reads it dry.
  task automatic test_word_queue_full();
    repeat (WORD_DEPTH / 2 + 1) begin
      bus_write(dlmh_pkg::HS_START);
      bus_write(32'hDEAD_0000);
    end
    repeat (WORD_DEPTH + 2) bus_read(dlmh_pkg::ADDR_DATA);
  endtask

  // All response slots busy: a further push is refused. One chunk overruns
  // the chunk size so the stored size saturates.
  task automatic test_response_full();
    drain_responses();
    push_chunk(CHUNK + 2, 1'b1);
    repeat (SLOTS - 1) push_chunk($urandom_range(1, 6), 1'b1);
    host_push(8'h5A, 1'b1);
    drain_responses();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items without gaps, so the block backs up and stalls its input.
  task automatic test_backpressure();
    no_idle = 1'b1;
    hold_request = 150;
    repeat (20) host_read(8'($urandom));
    repeat (40) bus_read(dlmh_pkg::ADDR_STATUS);
    no_idle = 1'b0;
  endtask

  // Mostly well-formed host and console exchanges, with random noise and
  // spoiled handshakes mixed in, up to the item target of the run.
  task automatic test_random_traffic();
    int unsigned r;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        push_chunk($urandom_range(1, 12), $urandom_range(0, 9) != 0);
      end else if (r < 45) begin
        console_handshake($urandom_range(0, 5) == 0, pick_opcode());
      end else if (r < 55) begin
        host_read(8'($urandom));
      end else if (r < 60) begin
        no_idle = ~no_idle;
      end else begin
        send_item(dlmh_pkg::cmd_e'($urandom_range(0, 3)),
                  ($urandom_range(0, 1) != 0) ? 5'($urandom) : 5'(4 * $urandom_range(0, 1)),
                  $urandom, 8'($urandom), 1'($urandom), 8'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned waited;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = dlmh_pkg::CMD_BUS_READ;
    bus_address_i  = '0;
    write_data_i   = '0;
    host_byte_i    = '0;
    host_last_i    = 1'b0;
    buffer_index_i = '0;
    no_idle        = 1'b0;
    hold_request   = 0;
    error_count    = 0;
    items_sent     = 0;
    results_checked = 0;
    handshakes_run = 0;

    // Shadow state after reset.
    words_rd = 0; words_wr = 0; words_count = 0;
    slot_rd = 0; slot_wr = 0; slot_count = 0; slot_fill = 0;
    hs_open = 1'b0; hs_write = 1'b0; hs_len = 0;
    cw_active = 1'b0; cw_expected = 0; cw_offset = 0;
    rr_active = 1'b0; rr_offset = 0;
    ready_flag = 1'b0;
    for (int i = 0; i < WORD_DEPTH; i++) mb_words[i] = '0;
    for (int i = 0; i < SLOTS; i++) slot_size[i] = 0;
    for (int i = 0; i < CMD_BYTES; i++) cmd_mem[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_corners();
    test_command_write();
    test_word_queue_full();
    test_response_full();
    test_backpressure();
    test_random_traffic();

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
      waited++;
      if (waited > 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
    // Each result is registered at its transfer; a short tail catches any
    // stray extra result.
    repeat (10) @(posedge clk_i);

    $display("Run covered %0d items, %0d results checked, %0d console handshakes.",
             items_sent, results_checked, handshakes_run);
    $display("Traffic included queue overflow, full response slots and long stalls.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
